/* rtl/tcw_pkg.sv */
// text console writer: shared constants, item types and sequencer states
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int TAB_STEP   = 8;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int PTR_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLX_W = COL_W + 1;
    localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [3:0]  fg_color;
        logic [3:0]  bg_color;
        logic [10:0] cell_address;
    } cmd_item_t;

    typedef struct packed {
        logic [10:0] cursor_location;
        logic [15:0] cell_value;
    } rsp_item_t;

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DONE   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_FILL   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

/* rtl/tcw_cmd_if.sv */
// command channel of the text console writer: valid/ready plus one command item
// depends on tcw_pkg
`default_nettype none

interface tcw_cmd_if;
    logic                valid;
    logic                ready;
    tcw_pkg::cmd_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tcw_rsp_if.sv */
// response channel of the text console writer: valid/ready plus one result item
// depends on tcw_pkg
`default_nettype none

interface tcw_rsp_if;
    logic                valid;
    logic                ready;
    tcw_pkg::rsp_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/text_console_writer.sv */
// text console writer: screen memory, cursor and the sequencer that scrolls and clears
// depends on tcw_pkg, tcw_cmd_if and tcw_rsp_if
// sequencing: an accepted put, read or other item moves to the done state, which loads the
//   result register once the output is free, and no new item is taken until then; a put that moves
//   past the bottom row first copies every row up by one and then blanks the bottom row; clear
//   blanks every cell; all limited by the single write port of the screen memory
// reset: cursor homes and a blanking pass over every cell runs with cmd.ready low
`default_nettype none

module text_console_writer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcw_cmd_if.sink    cmd,
    tcw_rsp_if.source  rsp
);
    import tcw_pkg::*;

    logic [15:0] mem [CELL_COUNT];

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                copy_valid_reg, copy_valid_next;
    logic [ADDR_W-1:0]   copy_addr_reg, copy_addr_next;
    logic                rd_sel_reg, rd_sel_next;
    logic                out_valid_reg, out_valid_next;
    rsp_item_t           rsp_data_reg, rsp_data_next;
    logic [15:0]         rdata_reg;

    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [15:0]         mem_wdata;

    logic                accept, out_free;
    logic [ADDR_W-1:0]   cur_idx;
    logic [15:0]         addr_wide, idx_wide;
    logic                addr_ok, is_print, last_row, crlf, wrap, adv;
    logic [COLX_W-1:0]   col_ext, col_put;
    logic [7:0]          ch;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign cur_idx   = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign idx_wide  = 16'(cur_idx);
    assign addr_wide = 16'(cmd.data.cell_address);
    assign addr_ok   = addr_wide < 16'(CELL_COUNT);
    assign ch        = cmd.data.char_code;
    // bytes with the top bit set are not printable and are dropped
    assign is_print  = !ch[7] && (ch >= CH_SPACE);
    assign last_row  = (row_reg == ROW_W'(ROWS - 1));
    assign col_ext   = COLX_W'(col_reg);

    always_comb
    begin
        col_put = col_ext;
        crlf    = 1'b0;
        if (ch == CH_BS)
        begin
            if (col_reg != '0)
            begin
                col_put = col_ext - COLX_W'(1);
            end
        end
        else if (ch == CH_TAB)
        begin
            col_put = (col_ext + COLX_W'(TAB_STEP)) & ~COLX_W'(TAB_STEP - 1);
        end
        else if (ch == CH_CR || ch == CH_LF)
        begin
            col_put = '0;
            crlf    = 1'b1;
        end
        else if (is_print)
        begin
            col_put = col_ext + COLX_W'(1);
        end
    end

    assign wrap = (col_put >= COLX_W'(COLUMNS));
    assign adv  = crlf || wrap;

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        ptr_next        = ptr_reg;
        copy_valid_next = 1'b0;
        copy_addr_next  = copy_addr_reg;
        rd_sel_next     = rd_sel_reg;
        rsp_data_next   = rsp_data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_waddr       = cur_idx;
        mem_wdata       = {cmd.data.bg_color, cmd.data.fg_color, ch};
        mem_re          = 1'b0;
        mem_raddr       = addr_wide[ADDR_W-1:0];

        case (state_reg)
            ST_INIT, ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[ADDR_W-1:0];
                mem_wdata = BLANK_CELL;
                if (ptr_reg == PTR_W'(CELL_COUNT - 1))
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_sel_next = 1'b0;
                    state_next  = ST_DONE;
                    case (cmd.data.opcode)
                        OP_PUT:
                        begin
                            mem_we = is_print;
                            col_next = adv ? '0 : col_put[COL_W-1:0];
                            if (adv)
                            begin
                                if (last_row)
                                begin
                                    ptr_next   = PTR_W'(COLUMNS);
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            ptr_next   = '0;
                            state_next = ST_FILL;
                        end
                        OP_READ:
                        begin
                            mem_re      = addr_ok;
                            rd_sel_next = addr_ok;
                        end
                        default:
                        begin
                            rd_sel_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // read one row below, write the cell read in the previous cycle
                mem_we    = copy_valid_reg;
                mem_waddr = copy_addr_reg;
                mem_wdata = rdata_reg;
                if (ptr_reg < PTR_W'(CELL_COUNT))
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = ptr_reg[ADDR_W-1:0];
                    copy_valid_next = 1'b1;
                    copy_addr_next  = ptr_reg[ADDR_W-1:0] - ADDR_W'(COLUMNS);
                    ptr_next        = ptr_reg + PTR_W'(1);
                end
                else
                begin
                    ptr_next   = PTR_W'((ROWS - 1) * COLUMNS);
                    state_next = ST_FILL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_data_next.cursor_location = idx_wide[10:0];
                    rsp_data_next.cell_value      = rd_sel_reg ? rdata_reg : 16'h0000;
                    out_valid_next                = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            ptr_reg        <= '0;
            copy_valid_reg <= 1'b0;
            rd_sel_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            ptr_reg        <= ptr_next;
            copy_valid_reg <= copy_valid_next;
            rd_sel_reg     <= rd_sel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
        rsp_data_reg  <= rsp_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < COL_W'(COLUMNS)) && (row_reg <= ROW_W'(ROWS - 1)))
        else $error("cursor outside the screen");

    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.data.opcode == OP_CLEAR) |=>
            (state_reg == ST_FILL) && (cur_idx == '0) && (ptr_reg == '0))
        else $error("clear did not home the cursor and start the fill");

    a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_valid_reg |-> (state_reg == ST_SCROLL))
        else $error("pending row copy outside the scroll");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !rsp.ready) |=>
            (state_reg == ST_DONE) && $stable(rsp_data_reg))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

/* verif/tb_text_console_writer.sv */
`timescale 1ns / 1ps
// self-checking bench for text_console_writer: directed table, then random puts, reads, clears and unused opcodes
// depends on tcw_pkg, tcw_cmd_if, tcw_rsp_if and the text_console_writer rtl

module tb_text_console_writer;

    import tcw_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [7:0] CH_PRINT_LAST  = 8'h7F;
    localparam int         RANDOM_ITEMS   = 950;
    localparam int         SINK_HOLD      = 300;
    localparam int         STALL_LIMIT    = 20000;
    localparam int         DRAIN_CYCLES   = 2 * CELL_COUNT + 200;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic [10:0] addr;
        logic        typed;
        logic [10:0] cur;
        logic [15:0] val;
    } plan_row_t;

    // typed rows carry their own result, the rest use the shadow screen
    localparam int PLAN_LEN = 23;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{OP_READ,   8'h00, 4'h0, 4'h0, 11'd0,    1'b1, 11'd0,   16'h0F20},
        '{OP_READ,   8'h00, 4'h0, 4'h0, 11'h7FF,  1'b1, 11'd0,   16'h0000},
        '{OP_READ,   8'hFF, 4'hF, 4'hF, 11'd1999, 1'b1, 11'd0,   16'h0F20},
        '{OP_UNUSED, 8'hFF, 4'hF, 4'hF, 11'h7FF,  1'b1, 11'd0,   16'h0000},
        '{OP_PUT,    8'h41, 4'hF, 4'hF, 11'd0,    1'b1, 11'd1,   16'h0000},
        '{OP_READ,   8'h00, 4'h0, 4'h0, 11'd0,    1'b1, 11'd1,   16'hFF41},
        '{OP_PUT,    8'h7F, 4'h0, 4'h0, 11'h7FF,  1'b1, 11'd2,   16'h0000},
        '{OP_READ,   8'h00, 4'h0, 4'h0, 11'd1,    1'b1, 11'd2,   16'h007F},
        '{OP_PUT,    8'h20, 4'h5, 4'hA, 11'h555,  1'b0, 11'd0,   16'h0000},
        '{OP_PUT,    8'h80, 4'h1, 4'h2, 11'd0,    1'b1, 11'd3,   16'h0000},
        '{OP_PUT,    8'hFF, 4'hF, 4'hF, 11'h7FF,  1'b1, 11'd3,   16'h0000},
        '{OP_PUT,    8'h00, 4'h0, 4'h0, 11'd0,    1'b1, 11'd3,   16'h0000},
        '{OP_PUT,    8'h1F, 4'h7, 4'h7, 11'd0,    1'b1, 11'd3,   16'h0000},
        '{OP_PUT,    CH_BS, 4'h0, 4'h0, 11'd0,    1'b1, 11'd2,   16'h0000},
        '{OP_PUT,    CH_TAB, 4'h0, 4'h0, 11'd0,   1'b1, 11'd8,   16'h0000},
        '{OP_PUT,    CH_TAB, 4'h3, 4'hC, 11'd9,   1'b0, 11'd0,   16'h0000},
        '{OP_PUT,    CH_CR, 4'h0, 4'h0, 11'd0,    1'b1, 11'd80,  16'h0000},
        '{OP_PUT,    CH_BS, 4'h0, 4'h0, 11'd0,    1'b1, 11'd80,  16'h0000},
        '{OP_PUT,    CH_LF, 4'h0, 4'h0, 11'd0,    1'b1, 11'd160, 16'h0000},
        '{OP_PUT,    8'h7E, 4'h3, 4'h4, 11'd0,    1'b0, 11'd0,   16'h0000},
        '{OP_READ,   8'h00, 4'h0, 4'h0, 11'd160,  1'b0, 11'd0,   16'h0000},
        '{OP_CLEAR,  8'hFF, 4'hF, 4'hF, 11'h7FF,  1'b1, 11'd0,   16'h0000},
        '{OP_READ,   8'h00, 4'h0, 4'h0, 11'd160,  1'b1, 11'd0,   16'h0F20}
    };

    logic clk = 1'b0;
    logic rst_n;

    tcw_cmd_if cmd_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [15:0] shadow_screen [CELL_COUNT];
    int unsigned shadow_col;
    int unsigned shadow_row;
    rsp_item_t   due_rsp [$];
    rsp_item_t   got_want;
    int          fail_count = 0;
    int          src_idle   = 0;
    int          snk_idle   = 0;
    bit          hold_sink  = 1'b0;
    int          quiet_cycles = 0;

    initial
    begin
        for (int i = 0; i < CELL_COUNT; i++)
            shadow_screen[i] = BLANK_CELL;
        shadow_col = 0;
        shadow_row = 0;
    end

    function automatic void shadow_next_row();
        shadow_row++;
        if (shadow_row >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                shadow_screen[i] = BLANK_CELL;
            shadow_row = ROWS - 1;
        end
    endfunction

    // applies one command to the shadow screen and returns the cursor and cell it reports
    function automatic rsp_item_t screen_step(input cmd_item_t c);
        rsp_item_t   r;
        int unsigned idx;
        r.cell_value = '0;
        case (c.opcode)
            OP_PUT:
            begin
                if (c.char_code == CH_BS)
                begin
                    if (shadow_col != 0)
                        shadow_col--;
                end
                else if (c.char_code == CH_TAB)
                    shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
                else if (c.char_code == CH_CR || c.char_code == CH_LF)
                begin
                    shadow_col = 0;
                    shadow_next_row();
                end
                else if (c.char_code >= CH_SPACE && c.char_code <= CH_PRINT_LAST)
                begin
                    idx = shadow_row * COLUMNS + shadow_col;
                    if (idx < CELL_COUNT)
                        shadow_screen[idx] = {c.bg_color, c.fg_color, c.char_code};
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS)
                begin
                    shadow_col = 0;
                    shadow_next_row();
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                    shadow_screen[i] = BLANK_CELL;
                shadow_col = 0;
                shadow_row = 0;
            end
            OP_READ:
            begin
                if (c.cell_address < CELL_COUNT)
                    r.cell_value = shadow_screen[c.cell_address];
            end
            default:
            begin
            end
        endcase
        r.cursor_location = 11'(shadow_row * COLUMNS + shadow_col);
        return r;
    endfunction

    function automatic cmd_item_t random_cmd();
        cmd_item_t   c;
        int unsigned pick;
        int          here;
        c.opcode       = OP_PUT;
        c.char_code    = 8'($urandom);
        c.fg_color     = 4'($urandom);
        c.bg_color     = 4'($urandom);
        c.cell_address = 11'($urandom);
        pick = $urandom_range(999);
        if (pick < 600)
            c.char_code = 8'($urandom_range(CH_PRINT_LAST, CH_SPACE));
        else if (pick < 680)
            c.char_code = $urandom_range(1) ? CH_LF : CH_CR;
        else if (pick < 730)
            c.char_code = CH_TAB;
        else if (pick < 770)
            c.char_code = CH_BS;
        else if (pick < 790)
            c.char_code = 8'($urandom_range(31));
        else if (pick < 830)
            c.char_code = 8'($urandom_range(255, 128));
        else if (pick < 985)
        begin
            c.opcode = OP_READ;
            pick = $urandom_range(9);
            // mostly look at the rows just written so stored items get read back
            if (pick < 7)
            begin
                here = int'(shadow_row * COLUMNS + shadow_col) - int'($urandom_range(240));
                c.cell_address = (here < 0) ? 11'd0 : 11'(here);
            end
            else if (pick < 9)
                c.cell_address = 11'($urandom_range(CELL_COUNT - 1));
            else
                c.cell_address = 11'($urandom_range(2047, CELL_COUNT));
        end
        else if (pick < 988)
            c.opcode = OP_CLEAR;
        else
            c.opcode = OP_UNUSED;
        return c;
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_cmd(input cmd_item_t c, input logic typed, input rsp_item_t typed_rsp);
        rsp_item_t predicted;
        while ($urandom_range(99) < src_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = screen_step(c);
        due_rsp.push_back(typed ? typed_rsp : predicted);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_sink)
        begin
            rsp_ch.ready <= 1'b0;
            repeat (SINK_HOLD) @(negedge clk);
            hold_sink = 1'b0;
        end
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_rsp.size() == 0)
            begin
                $display("%0t unexpected item: cursor %0d cell %h", $time,
                         rsp_ch.data.cursor_location, rsp_ch.data.cell_value);
                fail_count++;
            end
            else
            begin
                got_want = due_rsp.pop_front();
                if (rsp_ch.data.cursor_location !== got_want.cursor_location)
                begin
                    $display("%0t cursor_location expected %0d actual %0d", $time,
                             got_want.cursor_location, rsp_ch.data.cursor_location);
                    fail_count++;
                end
                if (rsp_ch.data.cell_value !== got_want.cell_value)
                begin
                    $display("%0t cell_value expected %h actual %h", $time,
                             got_want.cell_value, rsp_ch.data.cell_value);
                    fail_count++;
                end
            end
        end
    end

    // scroll, clear and the blanking pass after reset each walk every cell of the screen
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t no handshake for %0d cycles, %0d items outstanding", $time,
                     quiet_cycles, due_rsp.size());
            $display("tb_text_console_writer: errors");
            $finish;
        end
    end

    initial
    begin
        cmd_item_t c;
        rsp_item_t typed_rsp;
        int        counted;
        bit        pressure_done;
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        pressure_done = 1'b0;
        src_idle      = 11;
        snk_idle      = 76;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (PLAN[i])
        begin
            c.opcode       = PLAN[i].op;
            c.char_code    = PLAN[i].ch;
            c.fg_color     = PLAN[i].fg;
            c.bg_color     = PLAN[i].bg;
            c.cell_address = PLAN[i].addr;
            typed_rsp.cursor_location = PLAN[i].cur;
            typed_rsp.cell_value      = PLAN[i].val;
            send_cmd(c, PLAN[i].typed, typed_rsp);
        end

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= RANDOM_ITEMS / 3 && counted < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle = 76;
                snk_idle = 11;
            end
            else if (counted >= 2 * RANDOM_ITEMS / 3 && !pressure_done)
            begin
                src_idle      = 0;
                snk_idle      = 0;
                hold_sink     = 1'b1;
                pressure_done = 1'b1;
            end
            c = random_cmd();
            send_cmd(c, 1'b0, '0);
            counted++;
        end
        cmd_ch.valid <= 1'b0;

        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_text_console_writer: clean");
        else
            $display("tb_text_console_writer: errors");
        $finish;
    end

endmodule
